// File: rtl/glyph_blit_clipped_macros.svh
// ----------------------------------------------------------------------------
// glyph_blit_clipped_macros
// assertion macros shared by the glyph blitter rtl
// ----------------------------------------------------------------------------
`ifndef GLYPH_BLIT_CLIPPED_MACROS_SVH
`define GLYPH_BLIT_CLIPPED_MACROS_SVH

// clocked assertion, off while in reset
`define GBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion checked during reset too
`define GBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// types and constants of the clipped glyph blitter
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int GLYPH_WIDTH_DEF  = 8;
  localparam int GLYPH_HEIGHT_DEF = 8;

  localparam int BITS_W  = 64;
  localparam int COORD_W = 16;
  localparam int DIM_W   = 14;
  localparam int PITCH_W = 16;
  localparam int COLOR_W = 32;
  localparam int OFF_W   = 29;
  localparam int POS_W   = 17;
  localparam int CIDX_W  = 2;

  typedef enum logic [CIDX_W-1:0] {
    CFG_FB_WIDTH  = 2'd0,
    CFG_FB_HEIGHT = 2'd1,
    CFG_ROW_PITCH = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

endpackage

// File: rtl/glyph_blit_clipped.sv
// ----------------------------------------------------------------------------
// glyph_blit_clipped
// clipped bitmap font glyph blitter, one pixel write per set and visible bit
// ----------------------------------------------------------------------------
// command channel: a word is taken when start is high and busy is low; it
// carries the glyph bitmap, origin and color. busy stays high while the glyph
// bitmap is shifted out one bit per cycle, lsb first, row by row.
// result channel: out_strobe marks each pixel write for one cycle; the
// receiver cannot stall, so every strobed word must be taken. out_last_write
// flags the final write of a glyph. a wholly clipped, rejected or empty glyph
// gives no word at all.
// config channel: cfg_ready is always high; write the registers only while
// busy is low. index 0 is the width, 1 the height, 2 the row pitch.
// walk: after the command is taken, the bitmap shifter steps through the cells up
// to the highest set bit (at most GLYPH_WIDTH*GLYPH_HEIGHT, capped at 64), then
// closes the walk and returns to idle. each write leaves in the cycle after the next
// visible pixel is found, the last one in the cycle after the close.
// reset: rst_n low clears the config registers to zero and idles the block.
// ----------------------------------------------------------------------------
`include "glyph_blit_clipped_macros.svh"

module glyph_blit_clipped #(
  parameter int GLYPH_WIDTH  = gbc_pkg::GLYPH_WIDTH_DEF,
  parameter int GLYPH_HEIGHT = gbc_pkg::GLYPH_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [gbc_pkg::BITS_W-1:0]    in_glyph_bits,
  input  logic [gbc_pkg::COORD_W-1:0]   in_origin_x,
  input  logic [gbc_pkg::COORD_W-1:0]   in_origin_y,
  input  logic [gbc_pkg::COLOR_W-1:0]   in_pixel_color,
  output logic                          out_strobe,
  output logic [gbc_pkg::OFF_W-1:0]     out_byte_offset,
  output logic [gbc_pkg::COLOR_W-1:0]   out_write_color,
  output logic                          out_last_write,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gbc_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [gbc_pkg::PITCH_W-1:0]   cfg_data
);

  localparam int CELLS = GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int COL_W = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GLYPH_WIDTH - 1);
  localparam logic [gbc_pkg::BITS_W-1:0] BIT_MASK =
    (CELLS >= gbc_pkg::BITS_W) ? {gbc_pkg::BITS_W{1'b1}}
                               : ((64'd1 << CELLS) - 64'd1);

  gbc_pkg::state_t state_r, state_nxt;

  logic [gbc_pkg::DIM_W-1:0]   width_r, width_nxt;
  logic [gbc_pkg::DIM_W-1:0]   height_r, height_nxt;
  logic [gbc_pkg::PITCH_W-1:0] pitch_r, pitch_nxt;

  logic [gbc_pkg::BITS_W-1:0]  bits_r, bits_nxt;
  logic [gbc_pkg::COORD_W-1:0] ox_r, ox_nxt;
  logic [gbc_pkg::POS_W-1:0]   px_r, px_nxt;
  logic [gbc_pkg::POS_W-1:0]   py_r, py_nxt;
  logic [COL_W-1:0]            col_r, col_nxt;
  logic [gbc_pkg::OFF_W-1:0]   line_r, line_nxt;
  logic [gbc_pkg::OFF_W-1:0]   off_r, off_nxt;
  logic [gbc_pkg::COLOR_W-1:0] color_r, color_nxt;
  logic                        pend_v_r, pend_v_nxt;
  logic [gbc_pkg::OFF_W-1:0]   pend_off_r, pend_off_nxt;

  logic                        out_strobe_r, out_strobe_nxt;
  logic [gbc_pkg::OFF_W-1:0]   out_off_r, out_off_nxt;
  logic [gbc_pkg::COLOR_W-1:0] out_color_r, out_color_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        accept;
  logic                        walk_end;
  logic                        walk_step;
  logic                        hit;
  logic [31:0]                 base_prod;
  logic [31:0]                 base_sum;
  logic [gbc_pkg::OFF_W-1:0]   line_next_row;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gbc_pkg::ST_IDLE: if (start) state_nxt = gbc_pkg::ST_WALK;
      gbc_pkg::ST_WALK: if (bits_r == '0) state_nxt = gbc_pkg::ST_IDLE;
      default:          state_nxt = gbc_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    busy      = 1'b0;
    walk_end  = 1'b0;
    walk_step = 1'b0;
    unique case (state_r)
      gbc_pkg::ST_IDLE: ;
      gbc_pkg::ST_WALK: begin
        busy      = 1'b1;
        walk_end  = (bits_r == '0);
        walk_step = (bits_r != '0);
      end
      default: ;
    endcase
  end

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // config registers
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    pitch_nxt  = pitch_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gbc_pkg::CFG_FB_WIDTH:  width_nxt  = cfg_data[gbc_pkg::DIM_W-1:0];
        gbc_pkg::CFG_FB_HEIGHT: height_nxt = cfg_data[gbc_pkg::DIM_W-1:0];
        gbc_pkg::CFG_ROW_PITCH: pitch_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  // bitmap walk
  assign base_prod = {16'b0, in_origin_y} * {16'b0, pitch_r};
  assign base_sum  = base_prod + {14'b0, in_origin_x, 2'b00};
  assign line_next_row = line_r + {13'b0, pitch_r};
  assign hit = bits_r[0]
            && (px_r < {3'b0, width_r})
            && (py_r < {3'b0, height_r});

  always_comb begin
    bits_nxt      = bits_r;
    ox_nxt        = ox_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    off_nxt       = off_r;
    color_nxt     = color_r;
    pend_v_nxt    = pend_v_r;
    pend_off_nxt  = pend_off_r;
    out_strobe_nxt = 1'b0;
    out_off_nxt   = out_off_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;
    if (accept) begin
      bits_nxt   = in_glyph_bits & BIT_MASK;
      ox_nxt     = in_origin_x;
      px_nxt     = {1'b0, in_origin_x};
      py_nxt     = {1'b0, in_origin_y};
      col_nxt    = '0;
      line_nxt   = base_sum[gbc_pkg::OFF_W-1:0];
      off_nxt    = base_sum[gbc_pkg::OFF_W-1:0];
      color_nxt  = in_pixel_color;
      pend_v_nxt = 1'b0;
    end else if (walk_step) begin
      bits_nxt = bits_r >> 1;
      if (col_r == COL_LAST) begin
        col_nxt  = '0;
        px_nxt   = {1'b0, ox_r};
        py_nxt   = py_r + 17'd1;
        line_nxt = line_next_row;
        off_nxt  = line_next_row;
      end else begin
        col_nxt = col_r + 1'b1;
        px_nxt  = px_r + 17'd1;
        off_nxt = off_r + 29'd4;
      end
      if (hit) begin
        pend_v_nxt   = 1'b1;
        pend_off_nxt = off_r;
        if (pend_v_r) begin
          out_strobe_nxt = 1'b1;
          out_off_nxt    = pend_off_r;
          out_color_nxt  = color_r;
          out_last_nxt   = 1'b0;
        end
      end
    end else if (walk_end) begin
      pend_v_nxt = 1'b0;
      if (pend_v_r) begin
        out_strobe_nxt = 1'b1;
        out_off_nxt    = pend_off_r;
        out_color_nxt  = color_r;
        out_last_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gbc_pkg::ST_IDLE;
      width_r      <= '0;
      height_r     <= '0;
      pitch_r      <= '0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      pitch_r      <= pitch_nxt;
      pend_v_r     <= pend_v_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r      <= bits_nxt;
    ox_r        <= ox_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    col_r       <= col_nxt;
    line_r      <= line_nxt;
    off_r       <= off_nxt;
    color_r     <= color_nxt;
    pend_off_r  <= pend_off_nxt;
    out_off_r   <= out_off_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_byte_offset = out_off_r;
  assign out_write_color = out_color_r;
  assign out_last_write  = out_last_r;

  `GBC_ASSERT(a_strobe_from_walk, out_strobe |-> $past(state_r == gbc_pkg::ST_WALK), "word strobed without a walk")
  `GBC_ASSERT(a_idle_no_pending, state_r == gbc_pkg::ST_IDLE |-> !pend_v_r, "pending write left behind in idle")
  `GBC_ASSERT(a_last_then_quiet, (out_strobe && out_last_write) |=> !out_strobe, "word strobed right after last write")
  `GBC_ASSERT(a_end_flushes, (walk_end && pend_v_r) |=> (out_strobe && out_last_write), "pending write not closed as last")

endmodule

// File: tb/glyph_blit_clipped_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_blit_clipped_check
// watches the command, config and pixel write channels of the glyph blitter,
// works out every pixel write each accepted glyph should give and compares the
// strobed words, in order and field by field, against them
// ----------------------------------------------------------------------------
module glyph_blit_clipped_check #(
  parameter int GLYPH_WIDTH  = gbc_pkg::GLYPH_WIDTH_DEF,
  parameter int GLYPH_HEIGHT = gbc_pkg::GLYPH_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [gbc_pkg::BITS_W-1:0]  in_glyph_bits,
  input  logic [gbc_pkg::COORD_W-1:0] in_origin_x,
  input  logic [gbc_pkg::COORD_W-1:0] in_origin_y,
  input  logic [gbc_pkg::COLOR_W-1:0] in_pixel_color,
  input  logic                        out_strobe,
  input  logic [gbc_pkg::OFF_W-1:0]   out_byte_offset,
  input  logic [gbc_pkg::COLOR_W-1:0] out_write_color,
  input  logic                        out_last_write,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [gbc_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [gbc_pkg::PITCH_W-1:0] cfg_data,
  output int unsigned                 fail_count,
  output int unsigned                 pending_words,
  output int unsigned                 checked_words
);

  typedef struct packed {
    logic [gbc_pkg::OFF_W-1:0]   byte_offset;
    logic [gbc_pkg::COLOR_W-1:0] write_color;
    logic                        last_write;
  } pixel_write_t;

  pixel_write_t                pixel_writes[$];
  pixel_write_t                want;
  logic [gbc_pkg::DIM_W-1:0]   fb_width;
  logic [gbc_pkg::DIM_W-1:0]   fb_height;
  logic [gbc_pkg::PITCH_W-1:0] row_pitch;

  // walk the bitmap lsb first, row by row, keeping set and visible pixels
  task automatic queue_glyph_writes(input logic [gbc_pkg::BITS_W-1:0] bits,
                                    input logic [gbc_pkg::COORD_W-1:0] ox,
                                    input logic [gbc_pkg::COORD_W-1:0] oy,
                                    input logic [gbc_pkg::COLOR_W-1:0] color);
    pixel_write_t w;
    logic [63:0]  px;
    logic [63:0]  py;
    logic [63:0]  offset;
    int           bit_pos;
    int           found;
    found = 0;
    if (ox < fb_width && oy < fb_height) begin
      for (int r = 0; r < GLYPH_HEIGHT; r++) begin
        for (int c = 0; c < GLYPH_WIDTH; c++) begin
          bit_pos = r * GLYPH_WIDTH + c;
          px = {48'b0, ox} + 64'(c);
          py = {48'b0, oy} + 64'(r);
          if (bit_pos < gbc_pkg::BITS_W) begin
            if (bits[bit_pos] && px < {50'b0, fb_width} && py < {50'b0, fb_height}) begin
              offset = py * {48'b0, row_pitch} + px * 64'd4;
              w.byte_offset = offset[gbc_pkg::OFF_W-1:0];
              w.write_color = color;
              w.last_write  = 1'b0;
              pixel_writes.push_back(w);
              found++;
            end
          end
        end
      end
      if (found > 0) pixel_writes[pixel_writes.size()-1].last_write = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pixel_writes.delete();
      fb_width  = '0;
      fb_height = '0;
      row_pitch = '0;
    end else begin
      if (out_strobe) begin
        if (pixel_writes.size() == 0) begin
          $error("pixel write with none expected: byte_offset %0h color %0h last %0b",
                 out_byte_offset, out_write_color, out_last_write);
          fail_count++;
        end else begin
          want = pixel_writes.pop_front();
          if (out_byte_offset !== want.byte_offset) begin
            $error("byte_offset mismatch: expected %0h, actual %0h",
                   want.byte_offset, out_byte_offset);
            fail_count++;
          end
          if (out_write_color !== want.write_color) begin
            $error("write_color mismatch: expected %0h, actual %0h",
                   want.write_color, out_write_color);
            fail_count++;
          end
          if (out_last_write !== want.last_write) begin
            $error("last_write mismatch: expected %0b, actual %0b",
                   want.last_write, out_last_write);
            fail_count++;
          end
          checked_words++;
        end
      end
      if (start && !busy)
        queue_glyph_writes(in_glyph_bits, in_origin_x, in_origin_y, in_pixel_color);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          gbc_pkg::CFG_FB_WIDTH:  fb_width  = cfg_data[gbc_pkg::DIM_W-1:0];
          gbc_pkg::CFG_FB_HEIGHT: fb_height = cfg_data[gbc_pkg::DIM_W-1:0];
          gbc_pkg::CFG_ROW_PITCH: row_pitch = cfg_data;
          default: ;
        endcase
      end
    end
    pending_words = pixel_writes.size();
  end

endmodule

// File: tb/glyph_blit_clipped_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_blit_clipped_test
// drives glyph commands and framebuffer geometry into the clipped glyph
// blitter: directed edge cases (clipping, rejection, wrap, tiny and huge
// framebuffers) followed by random glyphs over several geometries, with
// random sender gaps; the checker beside the block predicts the writes
// ----------------------------------------------------------------------------
module glyph_blit_clipped_test;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [gbc_pkg::CIDX_W-1:0] CFG_SPARE = 2'd3;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [gbc_pkg::BITS_W-1:0]  in_glyph_bits;
  logic [gbc_pkg::COORD_W-1:0] in_origin_x;
  logic [gbc_pkg::COORD_W-1:0] in_origin_y;
  logic [gbc_pkg::COLOR_W-1:0] in_pixel_color;
  logic                        out_strobe;
  logic [gbc_pkg::OFF_W-1:0]   out_byte_offset;
  logic [gbc_pkg::COLOR_W-1:0] out_write_color;
  logic                        out_last_write;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [gbc_pkg::CIDX_W-1:0]  cfg_index;
  logic [gbc_pkg::PITCH_W-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned checked_words;
  int unsigned cycle_count;
  int unsigned glyphs_sent;
  int unsigned geometries;
  int          cur_width;
  int          cur_height;
  bit          idle_on;

  glyph_blit_clipped u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_glyph_bits  (in_glyph_bits),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_pixel_color (in_pixel_color),
    .out_strobe     (out_strobe),
    .out_byte_offset(out_byte_offset),
    .out_write_color(out_write_color),
    .out_last_write (out_last_write),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  glyph_blit_clipped_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_glyph_bits  (in_glyph_bits),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_pixel_color (in_pixel_color),
    .out_strobe     (out_strobe),
    .out_byte_offset(out_byte_offset),
    .out_write_color(out_write_color),
    .out_last_write (out_last_write),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_words  (pending_words),
    .checked_words  (checked_words)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("glyph_blit_clipped test failed");
      $finish;
    end
  end

  // start is left high so a following command can go out back to back
  task automatic send_glyph(input logic [gbc_pkg::BITS_W-1:0] bits,
                            input logic [gbc_pkg::COORD_W-1:0] ox,
                            input logic [gbc_pkg::COORD_W-1:0] oy,
                            input logic [gbc_pkg::COLOR_W-1:0] color);
    start          <= 1'b1;
    in_glyph_bits  <= bits;
    in_origin_x    <= ox;
    in_origin_y    <= oy;
    in_pixel_color <= color;
    @(posedge clk);
    while (busy) @(posedge clk);
    glyphs_sent++;
  endtask

  task automatic pause_sender();
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic cfg_write(input logic [gbc_pkg::CIDX_W-1:0] idx,
                           input logic [gbc_pkg::PITCH_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [gbc_pkg::PITCH_W-1:0] w,
                              input logic [gbc_pkg::PITCH_W-1:0] h,
                              input logic [gbc_pkg::PITCH_W-1:0] pitch);
    cfg_write(gbc_pkg::CFG_FB_WIDTH, w);
    cfg_write(gbc_pkg::CFG_FB_HEIGHT, h);
    cfg_write(gbc_pkg::CFG_ROW_PITCH, pitch);
    cfg_valid  <= 1'b0;
    cur_width  = int'(w[gbc_pkg::DIM_W-1:0]);
    cur_height = int'(h[gbc_pkg::DIM_W-1:0]);
    geometries++;
  endtask

  // rejected or wholly clipped glyphs leave no word, so let the walker finish too
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [gbc_pkg::BITS_W-1:0] random_bits();
    logic [gbc_pkg::BITS_W-1:0] a;
    logic [gbc_pkg::BITS_W-1:0] b;
    logic [gbc_pkg::BITS_W-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    unique case ($urandom_range(0, 7))
      0, 1:    return a & b & c;
      2:       return a | b;
      3:       return '1;
      4:       return 64'd1 << $urandom_range(0, 63);
      default: return a;
    endcase
  endfunction

  // mostly inside the framebuffer, often hugging the far edge
  function automatic logic [gbc_pkg::COORD_W-1:0] random_coord(input int limit);
    int near;
    near = (limit - 1 < 9) ? limit - 1 : 9;
    unique case ($urandom_range(0, 15))
      0, 1, 2, 3: return 16'(limit - 1 - int'($urandom_range(0, near)));
      4:          return '0;
      5:          return 16'($urandom_range(0, 65535));
      6:          return 16'(limit + int'($urandom_range(0, 3)));
      default:    return 16'($urandom_range(0, limit - 1));
    endcase
  endfunction

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_glyph_bits  = '0;
    in_origin_x    = '0;
    in_origin_y    = '0;
    in_pixel_color = '0;
    cfg_valid      = 1'b0;
    cfg_index      = gbc_pkg::CFG_FB_WIDTH;
    cfg_data       = '0;
    glyphs_sent    = 0;
    geometries     = 0;
    idle_on        = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero geometry after reset rejects everything
    send_glyph('1, 16'd0, 16'd0, 32'hffff_ffff);
    send_glyph(64'h0000_0000_0000_0001, 16'd0, 16'd0, 32'h1234_5678);
    wait_drained();

    set_geometry(16'd40, 16'd24, 16'd160);
    send_glyph('1, 16'd0, 16'd0, 32'hffff_ffff);
    pause_sender();
    send_glyph('0, 16'd0, 16'd0, 32'h0000_0000);
    send_glyph(64'h0000_0000_0000_0001, 16'd5, 16'd5, 32'h0000_0001);
    pause_sender();
    send_glyph(64'h8000_0000_0000_0000, 16'd10, 16'd10, 32'h8000_0000);
    send_glyph('1, 16'd36, 16'd20, 32'hdead_beef);
    send_glyph('1, 16'd39, 16'd23, 32'h0bad_cafe);
    pause_sender();
    send_glyph('1, 16'd40, 16'd0, 32'h1111_1111);
    send_glyph('1, 16'd0, 16'd24, 32'h2222_2222);
    send_glyph('1, 16'hffff, 16'hffff, 32'h3333_3333);
    send_glyph(64'hfefe_fefe_fefe_fefe, 16'd39, 16'd0, 32'h4444_4444);
    pause_sender();
    send_glyph(64'haa55_aa55_aa55_aa55, 16'd16, 16'd8, 32'h5a5a_a5a5);
    send_glyph(64'h0000_0000_0000_00ff, 16'd0, 16'd23, 32'h7777_7777);
    send_glyph(64'h0101_0101_0101_0101, 16'd39, 16'd0, 32'h9999_9999);
    wait_drained();

    // widest registers with upper data bits set; offsets wrap
    set_geometry(16'hffff, 16'hffff, 16'hffff);
    send_glyph('1, 16'd16379, 16'd16379, 32'ha5a5_a5a5);
    send_glyph('1, 16'd16380, 16'd0, 32'h5a5a_5a5a);
    send_glyph(random_bits(), 16'd8191, 16'd8191, $urandom);
    wait_drained();

    set_geometry(16'd1, 16'd1, 16'd0);
    send_glyph('1, 16'd0, 16'd0, 32'hc0de_c0de);
    send_glyph(64'h0000_0000_0000_0002, 16'd0, 16'd0, 32'h0000_ffff);
    send_glyph('1, 16'd1, 16'd0, 32'hffff_0000);
    wait_drained();

    set_geometry(16'd0, 16'd8192, 16'hffff);
    send_glyph('1, 16'd0, 16'd0, 32'h0f0f_0f0f);
    send_glyph(64'h0000_0000_0000_0001, 16'd0, 16'd100, 32'hf0f0_f0f0);
    wait_drained();

    // writes to the unused index must not disturb the geometry
    cfg_write(CFG_SPARE, 16'hffff);
    cfg_write(CFG_SPARE, 16'h0000);

    for (int phase = 0; phase < 5; phase++) begin
      unique case (phase)
        0: set_geometry(16'd8192, 16'd8192, 16'd32768);
        1: set_geometry(16'($urandom_range(1, 24)), 16'($urandom_range(1, 24)),
                        16'($urandom_range(0, 65535)));
        default: set_geometry(16'($urandom_range(1, 16383)), 16'($urandom_range(1, 16383)),
                              16'($urandom_range(0, 65535)));
      endcase
      for (int n = 0; n < 36; n++) begin
        if (n % 12 == 0) idle_on = (phase < 4) && ($urandom_range(0, 2) != 0);
        send_glyph(random_bits(), random_coord(cur_width), random_coord(cur_height), $urandom);
        pause_sender();
      end
      wait_drained();
    end

    $display("sent %0d glyph commands across %0d framebuffer geometries", glyphs_sent,
             geometries);
    $display("checked %0d pixel writes, covering clipping, rejection and offset wrap",
             checked_words);
    if (fail_count == 0 && pending_words == 0) begin
      $display("glyph_blit_clipped test passed");
    end else begin
      $display("glyph_blit_clipped test failed");
    end
    $finish;
  end

endmodule
